// File: hw/rtl/hocc_pkg.sv
// Shared types, constants and elaboration helpers for the odd-parity Hamming codec.
// Used by hocc_codec and hamming_odd_parity_codec; depends on nothing else.
package hocc_pkg;

    localparam int WORD_W           = 38;
    localparam int POS_MAX          = 63;
    localparam int POS_W            = 6;
    localparam int MSG_W            = 6;
    localparam int PAR_MAX          = 6;
    localparam int DEF_MAX_MSG_BITS = 32;
    localparam int RESET_MSG_BITS   = 32;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    typedef struct packed {
        logic [POS_W-1:0] par_mask;
        logic [POS_W-1:0] code_len;
    } t_code_cfg;

    typedef struct packed {
        logic [WORD_W-1:0] code_word;
        logic [POS_W-1:0]  error_position;
        logic              error_found;
        logic              position_invalid;
    } t_result;

    function automatic t_code_cfg code_cfg_of(input logic [MSG_W-1:0] raw, input int max_bits);
        int        m;
        int        r;
        bit        done;
        t_code_cfg cfg;
        m    = int'(raw);
        r    = 0;
        done = 1'b0;
        if (m < 1) begin
            m = 1;
        end
        if (m > max_bits) begin
            m = max_bits;
        end
        for (int i = 0; i <= PAR_MAX; i++) begin
            if (!done) begin
                if (m + r + 1 > (1 << r)) begin
                    r = r + 1;
                end else begin
                    done = 1'b1;
                end
            end
        end
        cfg.par_mask = POS_W'((1 << r) - 1);
        cfg.code_len = POS_W'(m + r);
        return cfg;
    endfunction

    function automatic int data_index(input int p);
        int npow;
        npow = 0;
        for (int k = 0; k <= PAR_MAX; k++) begin
            if ((1 << k) <= p) begin
                npow = npow + 1;
            end
        end
        return p - 1 - npow;
    endfunction

    function automatic logic [POS_MAX-1:0] group_mask(input int k);
        logic [POS_MAX-1:0] mask;
        mask = '0;
        for (int p = 1; p <= POS_MAX; p++) begin
            mask[p-1] = ((p >> k) & 1) != 0;
        end
        return mask;
    endfunction

endpackage

// File: hw/rtl/hocc_codec.sv
// Combinational encode and check/correct logic for one word.
// Depends on hocc_pkg for the field widths, the op codes and the parity group masks.
module hocc_codec (
    input  hocc_pkg::t_op                    i_op,
    input  logic [hocc_pkg::WORD_W-1:0]      i_word,
    input  hocc_pkg::t_code_cfg              i_cfg,
    output hocc_pkg::t_result                o_res
);
    import hocc_pkg::*;

    logic [POS_MAX-1:0] enc_data;
    logic [POS_MAX-1:0] dec_data;
    logic [POS_MAX-1:0] pos_en;
    logic [POS_MAX-1:0] flip_sel;
    logic [POS_MAX-1:0] base;
    logic [POS_MAX-1:0] par_vec;
    logic [POS_MAX-1:0] code;
    logic [PAR_MAX-1:0] grp_odd;
    logic [POS_W-1:0]   syn;
    logic               found;
    logic               invalid;

    for (genvar p = 1; p <= POS_MAX; p++) begin : g_pos
        localparam bit IS_PAR = (p & (p - 1)) == 0;
        localparam int J      = data_index(p);
        if (!IS_PAR && J < WORD_W) begin : g_enc
            assign enc_data[p-1] = i_word[J];
        end else begin : g_enc_zero
            assign enc_data[p-1] = 1'b0;
        end
        if (p <= WORD_W) begin : g_dec
            assign dec_data[p-1] = i_word[p-1];
        end else begin : g_dec_zero
            assign dec_data[p-1] = 1'b0;
        end
        assign pos_en[p-1]   = (POS_W'(p) <= i_cfg.code_len);
        assign flip_sel[p-1] = (syn == POS_W'(p));
    end

    assign base = pos_en & ((i_op == OP_ENCODE) ? enc_data : dec_data);

    always_comb begin
        for (int k = 0; k < PAR_MAX; k++) begin
            grp_odd[k] = ^(base & group_mask(k));
        end
    end

    assign syn     = POS_W'(~grp_odd) & i_cfg.par_mask;
    assign found   = |syn;
    assign invalid = syn > i_cfg.code_len;

    always_comb begin
        par_vec = '0;
        for (int k = 0; k < PAR_MAX; k++) begin
            par_vec[(1 << k) - 1] = syn[k];
        end
    end

    always_comb begin
        o_res = '0;
        case (i_op)
            OP_ENCODE: begin
                code = base | par_vec;
            end
            OP_DECODE: begin
                code                   = base ^ (flip_sel & {POS_MAX{~invalid}});
                o_res.error_position   = syn;
                o_res.error_found      = found;
                o_res.position_invalid = invalid;
            end
            default: begin
                code = base;
            end
        endcase
        o_res.code_word = code[WORD_W-1:0];
    end

endmodule

// File: hw/rtl/hamming_odd_parity_codec.sv
// Top level of the odd-parity Hamming single-error-correcting codec.
// An accepted word passes through an input register, then the parity trees of hocc_codec, then the
// result register. Throughput is one word per cycle while the receiver does not stall the output.
// Synchronous active-low reset empties both stages and sets the message length to 32 bits.
// Depends on hocc_pkg and hocc_codec.
module hamming_odd_parity_codec #(
    parameter int MAX_MSG_BITS = hocc_pkg::DEF_MAX_MSG_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hocc_pkg::MSG_W-1:0]      i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  hocc_pkg::t_op                   i_op,
    input  logic [hocc_pkg::WORD_W-1:0]     i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [hocc_pkg::WORD_W-1:0]     o_code_word,
    output logic [hocc_pkg::POS_W-1:0]      o_error_position,
    output logic                            o_error_found,
    output logic                            o_position_invalid
);
    import hocc_pkg::*;

    t_code_cfg          r_cfg;
    t_code_cfg          n_cfg;
    logic               r_s1_valid;
    logic               n_s1_valid;
    t_op                r_s1_op;
    logic [WORD_W-1:0]  r_s1_word;
    logic               r_out_valid;
    logic               n_out_valid;
    t_result            r_out_res;
    t_result            res;
    logic               in_take;
    logic               s1_move;

    assign n_cfg      = code_cfg_of(i_cfg_wdata, MAX_MSG_BITS);
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && r_out_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;

    assign n_s1_valid  = in_take || (r_s1_valid && !s1_move);
    assign n_out_valid = s1_move || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= code_cfg_of(MSG_W'(RESET_MSG_BITS), MAX_MSG_BITS);
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= n_cfg;
            end
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_op   <= i_op;
            r_s1_word <= i_in_word;
        end
        if (s1_move) begin
            r_out_res <= res;
        end
    end

    hocc_codec u_codec (
        .i_op   (r_s1_op),
        .i_word (r_s1_word),
        .i_cfg  (r_cfg),
        .o_res  (res)
    );

    assign o_out_valid        = r_out_valid;
    assign o_code_word        = r_out_res.code_word;
    assign o_error_position   = r_out_res.error_position;
    assign o_error_found      = r_out_res.error_found;
    assign o_position_invalid = r_out_res.position_invalid;

    a_invalid_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_res.position_invalid |-> r_out_res.error_found)
        else $error("Invalid position reported without an error.");

    a_syndrome_in_groups: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_res.error_position & ~r_cfg.par_mask) == '0)
        else $error("Syndrome has a bit outside the active parity groups.");

    a_corrected_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_res.error_found && !r_out_res.position_invalid
        |-> r_out_res.error_position <= r_cfg.code_len)
        else $error("Corrected position lies beyond the codeword.");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_s1_valid)
        else $error("Accepted word did not reach the input register.");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_res))
        else $error("Stalled result word was lost or changed.");

endmodule

// File: test/hamming_odd_parity_codec_checker.sv
`timescale 1ns / 1ps
// Checker for the odd-parity Hamming codec: it predicts each result word from the input channel.
// It keeps its own copy of the message length and compares every result word field by field.
// Depends on hocc_pkg only.
module hamming_odd_parity_codec_checker #(
    parameter int MAX_MSG_BITS = hocc_pkg::DEF_MAX_MSG_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hocc_pkg::MSG_W-1:0]        i_cfg_wdata,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  hocc_pkg::t_op                     i_op,
    input  logic [hocc_pkg::WORD_W-1:0]       i_in_word,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [hocc_pkg::WORD_W-1:0]       i_code_word,
    input  logic [hocc_pkg::POS_W-1:0]        i_error_position,
    input  logic                              i_error_found,
    input  logic                              i_position_invalid,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_code_len,
    output int                                o_checked,
    output int                                o_corrected,
    output int                                o_flagged
);
    import hocc_pkg::*;

    logic [MSG_W-1:0] msg_len = MSG_W'(RESET_MSG_BITS);
    t_result          expected_words[$];
    t_result          want;
    int               errors    = 0;
    int               checked   = 0;
    int               corrected = 0;
    int               flagged   = 0;

    function automatic int code_length(input logic [MSG_W-1:0] raw);
        int m;
        int r;
        m = int'(raw);
        if (m < 1) begin
            m = 1;
        end
        if (m > MAX_MSG_BITS) begin
            m = MAX_MSG_BITS;
        end
        r = 0;
        while (m + r + 1 > (1 << r)) begin
            r++;
        end
        return m + r;
    endfunction

    function automatic logic group_parity(input logic [WORD_W-1:0] cw, input int n, input int k);
        logic par;
        par = 1'b0;
        for (int p = 1; p <= n; p++) begin
            if (((p >> k) & 1) != 0) begin
                par ^= cw[p-1];
            end
        end
        return par;
    endfunction

    function automatic t_result predict_word(input t_op op, input logic [WORD_W-1:0] w,
                                             input int n);
        logic [WORD_W-1:0] cw;
        int                j;
        int                syn;
        t_result           res;
        cw  = '0;
        j   = 0;
        syn = 0;
        if (op == OP_ENCODE) begin
            for (int p = 1; p <= n; p++) begin
                if ((p & (p - 1)) != 0) begin
                    cw[p-1] = w[j];
                    j++;
                end
            end
            for (int k = 0; (1 << k) <= n; k++) begin
                if (!group_parity(cw, n, k)) begin
                    cw[(1 << k) - 1] = 1'b1;
                end
            end
        end else begin
            for (int p = 1; p <= n; p++) begin
                cw[p-1] = w[p-1];
            end
            for (int k = 0; (1 << k) <= n; k++) begin
                if (!group_parity(cw, n, k)) begin
                    syn |= 1 << k;
                end
            end
            if (syn != 0 && syn <= n) begin
                cw[syn-1] = ~cw[syn-1];
            end
        end
        res.code_word        = cw;
        res.error_position   = POS_W'(syn);
        res.error_found      = (syn != 0);
        res.position_invalid = (syn > n);
        return res;
    endfunction

    assign o_code_len = code_length(msg_len);

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            msg_len = MSG_W'(RESET_MSG_BITS);
            expected_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("Result word arrived with no word outstanding.");
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    checked++;
                    if (i_code_word !== want.code_word) begin
                        $error("code_word: expected %h, actual %h", want.code_word, i_code_word);
                        errors++;
                    end
                    if (i_error_position !== want.error_position) begin
                        $error("error_position: expected %0d, actual %0d",
                               want.error_position, i_error_position);
                        errors++;
                    end
                    if (i_error_found !== want.error_found) begin
                        $error("error_found: expected %0b, actual %0b",
                               want.error_found, i_error_found);
                        errors++;
                    end
                    if (i_position_invalid !== want.position_invalid) begin
                        $error("position_invalid: expected %0b, actual %0b",
                               want.position_invalid, i_position_invalid);
                        errors++;
                    end
                    if (want.position_invalid) begin
                        flagged++;
                    end else if (want.error_found) begin
                        corrected++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_words.push_back(predict_word(i_op, i_in_word, code_length(msg_len)));
            end
            if (i_cfg_we) begin
                msg_len = i_cfg_wdata;
            end
        end
        o_pending    <= expected_words.size();
        o_fail_count <= errors;
        o_checked    <= checked;
        o_corrected  <= corrected;
        o_flagged    <= flagged;
    end

endmodule

// File: test/hamming_odd_parity_codec_tb.sv
`timescale 1ns / 1ps
// Top of the odd-parity Hamming codec testbench: clock, reset, stimulus and the verdict.
// Depends on hocc_pkg, hamming_odd_parity_codec and hamming_odd_parity_codec_checker.
module hamming_odd_parity_codec_tb;
    import hocc_pkg::*;

    localparam int PHASES          = 11;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 6;
    localparam int CYCLE_LIMIT     = 400000;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_cfg_we     = 1'b0;
    logic [MSG_W-1:0]  i_cfg_wdata  = '0;
    logic              i_in_valid   = 1'b0;
    t_op               i_op         = OP_ENCODE;
    logic [WORD_W-1:0] i_in_word    = '0;
    logic              i_out_stall  = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [WORD_W-1:0] o_code_word;
    logic [POS_W-1:0]  o_error_position;
    logic              o_error_found;
    logic              o_position_invalid;

    int fail_count;
    int pending;
    int code_len;
    int checked;
    int corrected;
    int flagged;
    int cycle_count  = 0;
    int hold_asks    = 0;
    int holds_served = 0;
    bit calm         = 1'b0;
    int msg_settings [PHASES];

    hamming_odd_parity_codec dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_op               (i_op),
        .i_in_word          (i_in_word),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_code_word        (o_code_word),
        .o_error_position   (o_error_position),
        .o_error_found      (o_error_found),
        .o_position_invalid (o_position_invalid)
    );

    hamming_odd_parity_codec_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_op               (i_op),
        .i_in_word          (i_in_word),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_code_word        (o_code_word),
        .i_error_position   (o_error_position),
        .i_error_found      (o_error_found),
        .i_position_invalid (o_position_invalid),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_code_len         (code_len),
        .o_checked          (checked),
        .o_corrected        (corrected),
        .o_flagged          (flagged)
    );

    initial begin
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // The receiver stalls in random bursts, and once holds off for a long stretch on request.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_asks > holds_served) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_served++;
                i_out_stall <= 1'b0;
            end else if (!calm && $urandom_range(5, 0) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(19, 1)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                repeat ($urandom_range(40, 1) - 1) @(negedge i_clk);
            end
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return WORD_W'({$urandom, $urandom});
    endfunction

    function automatic logic [WORD_W-1:0] seal_parity(input logic [WORD_W-1:0] w, input int n);
        logic [WORD_W-1:0] cw;
        logic              par;
        cw = w;
        for (int p = n + 1; p <= WORD_W; p++) begin
            cw[p-1] = 1'b0;
        end
        for (int k = 0; (1 << k) <= n; k++) begin
            par = 1'b0;
            for (int p = 1; p <= n; p++) begin
                if (((p >> k) & 1) != 0) begin
                    par ^= cw[p-1];
                end
            end
            if (!par) begin
                cw[(1 << k) - 1] = ~cw[(1 << k) - 1];
            end
        end
        return cw;
    endfunction

    function automatic logic [WORD_W-1:0] damaged_codeword(input int n, input int flips,
                                                           input bit junk);
        logic [WORD_W-1:0] cw;
        logic [WORD_W-1:0] noise;
        int                a;
        int                b;
        cw = seal_parity(rand_word(), n);
        a  = $urandom_range(n, 1);
        if (flips >= 1) begin
            cw[a-1] = ~cw[a-1];
        end
        if (flips >= 2) begin
            b = $urandom_range(n - 1, 1);
            if (b >= a) begin
                b++;
            end
            cw[b-1] = ~cw[b-1];
        end
        if (junk) begin
            noise = rand_word();
            for (int p = 1; p <= n; p++) begin
                noise[p-1] = 1'b0;
            end
            cw |= noise;
        end
        return cw;
    endfunction

    task automatic send_word(input t_op op, input logic [WORD_W-1:0] w);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic idle_input(input int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        idle_input(1);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_msg_len(input int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= MSG_W'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        repeat (2) @(negedge i_clk);
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 25) begin
            send_word(OP_ENCODE, rand_word());
        end else if (pick < 85) begin
            send_word(OP_DECODE, damaged_codeword(code_len, (pick < 45) ? 0 : ((pick < 78) ? 1 : 2),
                                                  $urandom_range(3, 0) == 0));
        end else begin
            send_word(OP_DECODE, rand_word());
        end
    endtask

    initial begin
        logic [WORD_W-1:0] cw;
        msg_settings = '{0, 63, 1, 2, 3, 5, 11, 26, 31, 33, 32};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(OP_ENCODE, '0);
        send_word(OP_ENCODE, {WORD_W{1'b1}});
        send_word(OP_ENCODE, WORD_W'(1));
        send_word(OP_ENCODE, WORD_W'(1) << 31);
        send_word(OP_ENCODE, rand_word());
        send_word(OP_DECODE, '0);
        send_word(OP_DECODE, {WORD_W{1'b1}});
        cw = seal_parity(rand_word(), code_len);
        send_word(OP_DECODE, cw);
        cw[0] = ~cw[0];
        send_word(OP_DECODE, cw);
        cw = seal_parity(rand_word(), code_len);
        cw[code_len-1] = ~cw[code_len-1];
        send_word(OP_DECODE, cw);
        cw = seal_parity(rand_word(), code_len);
        cw[31] = ~cw[31];
        send_word(OP_DECODE, cw);
        cw = seal_parity(rand_word(), code_len);
        cw[2] = ~cw[2];
        send_word(OP_DECODE, cw);
        cw = seal_parity(rand_word(), code_len);
        cw[0] = ~cw[0];
        cw[1] = ~cw[1];
        send_word(OP_DECODE, cw);
        send_word(OP_DECODE, damaged_codeword(code_len, 2, 1'b0));
        send_word(OP_ENCODE, rand_word());

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            write_msg_len(msg_settings[ph]);
            calm = (ph == PHASES - 1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (ph == 5 && i == 20) begin
                    hold_asks++;
                end
                if (!calm && $urandom_range(11, 0) == 0) begin
                    idle_input($urandom_range(19, 1));
                end
                send_random_item();
            end
        end
        wait_drained();

        $display("Checked %0d result words across %0d message lengths, reset length included.",
                 checked, PHASES);
        $display("Decodes that corrected one bit: %0d; syndromes past the codeword: %0d.",
                 corrected, flagged);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
